// ----- rtl/core/icc_pkg.sv -----
`default_nettype none

package icc_pkg;

   localparam int unsigned COUNT_W       = 8;
   localparam int unsigned CHAN_W        = 8;
   localparam int unsigned DVD_W         = 16;
   localparam int unsigned QUO_W         = 11;
   localparam int unsigned SECTOR_STAGES = 11;
   localparam int unsigned SCALE_STAGES  = 8;
   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 8'd100;
   localparam logic [CHAN_W-1:0]  CHAN_FULL      = 8'd255;

   // hue sectors, named after the channel that ramps
   typedef enum logic [2:0] {
      SEC_GREEN_UP = 3'd0,
      SEC_RED_DOWN = 3'd1,
      SEC_BLUE_UP  = 3'd2,
      SEC_GREEN_DN = 3'd3,
      SEC_RED_UP   = 3'd4,
      SEC_BLUE_DN  = 3'd5
   } sector_type;

   typedef struct packed {
      logic                valid;
      logic                nonzero;
      sector_type          sector;
      logic [COUNT_W-1:0]  rem;
      logic [DVD_W-1:0]    dvd;
      logic [QUO_W-1:0]    quo;
   } stage_type;

endpackage

`default_nettype wire

// ----- rtl/core/icc_div_cell.sv -----
`default_nettype none

module icc_div_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [icc_pkg::COUNT_W-1:0]  divisor,
   input  wire icc_pkg::stage_type           stage_i,
   output icc_pkg::stage_type                stage_o
);

   icc_pkg::stage_type stage_ff, stage_in;
   logic [icc_pkg::COUNT_W:0] trial;
   logic [icc_pkg::COUNT_W:0] diff;
   logic                      ge;

   // one restoring division step
   always_comb begin
      trial    = {stage_i.rem, stage_i.dvd[icc_pkg::DVD_W-1]};
      diff     = trial - {1'b0, divisor};
      ge       = (trial >= {1'b0, divisor});
      stage_in = stage_i;
      stage_in.rem = ge ? diff[icc_pkg::COUNT_W-1:0] : trial[icc_pkg::COUNT_W-1:0];
      stage_in.dvd = {stage_i.dvd[icc_pkg::DVD_W-2:0], 1'b0};
      stage_in.quo = {stage_i.quo[icc_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

`default_nettype wire

// ----- rtl/core/iteration_count_colorizer.sv -----
`default_nettype none

// Escape-time colouriser: each transaction carries one iteration count and
// returns one RGB colour on the hue circle, hue = 360*count/max_iter at full
// saturation and value, zero count giving black, counts past max_iter held
// in the last sector. A new count is taken every cycle. The pipe holds 11
// division cells for sector and remainder, one scaling stage, 8 division
// cells for the ramp value and the output register. The pipeline only
// halts while a finished colour is stalled at the output. The user must
// write max_iter through csr_ while idle, unenforced; zero is treated as one.
module iteration_count_colorizer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [icc_pkg::COUNT_W-1:0]  req_iteration_count,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [icc_pkg::CHAN_W-1:0]   rsp_red,
   output      logic [icc_pkg::CHAN_W-1:0]   rsp_green,
   output      logic [icc_pkg::CHAN_W-1:0]   rsp_blue,
   input  wire logic                         csr_write_enable,
   input  wire logic [icc_pkg::COUNT_W-1:0]  csr_write_data
);

   localparam int unsigned NS = icc_pkg::SECTOR_STAGES;
   localparam int unsigned NR = icc_pkg::SCALE_STAGES;

   logic [icc_pkg::COUNT_W-1:0] max_iter_ff;
   logic [icc_pkg::COUNT_W-1:0] divisor;
   logic                        advance;

   icc_pkg::stage_type sec_chain [NS+1];
   icc_pkg::stage_type scl_chain [NR+1];
   icc_pkg::stage_type scale_ff, scale_in;

   logic [icc_pkg::QUO_W-1:0]   six;
   logic [icc_pkg::DVD_W-1:0]   prod;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [icc_pkg::CHAN_W-1:0]  red_ff, red_in;
   logic [icc_pkg::CHAN_W-1:0]  green_ff, green_in;
   logic [icc_pkg::CHAN_W-1:0]  blue_ff, blue_in;
   logic [icc_pkg::CHAN_W-1:0]  rise;
   logic [icc_pkg::CHAN_W-1:0]  fall;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= icc_pkg::MAX_ITER_RESET;
      end else if (csr_write_enable) begin
         max_iter_ff <= csr_write_data;
      end
   end

   // zero limit behaves as one
   assign divisor = (max_iter_ff == '0) ? {{(icc_pkg::COUNT_W-1){1'b0}}, 1'b1} : max_iter_ff;

   // whole pipe moves unless the output holds a stalled colour
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // 6n = 4n + 2n, left aligned in the dividend shifter
   always_comb begin
      six = {1'b0, req_iteration_count, 2'b00} + {2'b00, req_iteration_count, 1'b0};
      sec_chain[0]         = '0;
      sec_chain[0].valid   = req_valid;
      sec_chain[0].nonzero = (req_iteration_count != '0);
      sec_chain[0].sector  = icc_pkg::SEC_GREEN_UP;
      sec_chain[0].dvd     = {six, {(icc_pkg::DVD_W-icc_pkg::QUO_W){1'b0}}};
   end

   // sector division: one quotient bit per cell
   for (genvar i = 0; i < NS; i++) begin : g_sec
      icc_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .divisor (divisor),
         .stage_i (sec_chain[i]),
         .stage_o (sec_chain[i+1])
      );
   end

   // clamp sector, form 255*rem = 256*rem - rem and restart the shifter
   always_comb begin
      prod     = {sec_chain[NS].rem, 8'h00} - {8'h00, sec_chain[NS].rem};
      scale_in = sec_chain[NS];
      if (sec_chain[NS].quo > icc_pkg::QUO_W'(icc_pkg::SEC_BLUE_DN)) begin
         scale_in.sector = icc_pkg::SEC_BLUE_DN;
      end else begin
         scale_in.sector = icc_pkg::sector_type'(sec_chain[NS].quo[2:0]);
      end
      // high byte is below the divisor since rem < max_iter
      scale_in.rem = prod[icc_pkg::DVD_W-1:icc_pkg::DVD_W-icc_pkg::COUNT_W];
      scale_in.dvd = {prod[icc_pkg::DVD_W-icc_pkg::COUNT_W-1:0], {icc_pkg::COUNT_W{1'b0}}};
      scale_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else if (advance) begin
         scale_ff <= scale_in;
      end
   end

   assign scl_chain[0] = scale_ff;

   // ramp division: 8 quotient bits, one per cell
   for (genvar j = 0; j < NR; j++) begin : g_scl
      icc_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .divisor (divisor),
         .stage_i (scl_chain[j]),
         .stage_o (scl_chain[j+1])
      );
   end

   // fall = 255 - ceil(255*r/m), derived from rise and its remainder
   always_comb begin
      rise = scl_chain[NR].quo[icc_pkg::CHAN_W-1:0];
      fall = icc_pkg::CHAN_FULL - rise
           - {{(icc_pkg::CHAN_W-1){1'b0}}, (scl_chain[NR].rem != '0)};
      rsp_valid_in = scl_chain[NR].valid;
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (scl_chain[NR].nonzero) begin
         unique case (scl_chain[NR].sector)
            icc_pkg::SEC_GREEN_UP: begin
               red_in   = icc_pkg::CHAN_FULL;
               green_in = rise;
            end
            icc_pkg::SEC_RED_DOWN: begin
               red_in   = fall;
               green_in = icc_pkg::CHAN_FULL;
            end
            icc_pkg::SEC_BLUE_UP: begin
               green_in = icc_pkg::CHAN_FULL;
               blue_in  = rise;
            end
            icc_pkg::SEC_GREEN_DN: begin
               green_in = fall;
               blue_in  = icc_pkg::CHAN_FULL;
            end
            icc_pkg::SEC_RED_UP: begin
               red_in   = rise;
               blue_in  = icc_pkg::CHAN_FULL;
            end
            default: begin
               red_in   = icc_pkg::CHAN_FULL;
               blue_in  = fall;
            end
         endcase
      end
   end

   // output register, holds while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire

// ----- tb/tb_iteration_count_colorizer.sv -----
`default_nettype none

module tb_iteration_count_colorizer;
   timeunit 1ns;
   timeprecision 1ps;

   // pipeline depth of the block, taken from its own description
   localparam int unsigned LATENCY        = 21;
   localparam int unsigned RESET_CYCLES   = 9;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned PHASE_COUNT    = 12;
   localparam int unsigned PHASE_ITEMS    = 65;
   localparam int unsigned FLOOD_ITEMS    = 60;
   localparam int unsigned FLOOD_PHASE    = 5;

   typedef struct packed {
      logic [icc_pkg::CHAN_W-1:0] red;
      logic [icc_pkg::CHAN_W-1:0] green;
      logic [icc_pkg::CHAN_W-1:0] blue;
   } pixel_colour_type;

   // expected colours in order of acceptance, plus our own copy of max_iter
   class colour_scoreboard;
      pixel_colour_type            expected_colours[$];
      logic [icc_pkg::COUNT_W-1:0] max_iter;
      int                          errors;

      function new();
         max_iter = icc_pkg::MAX_ITER_RESET;
         errors   = 0;
      endfunction

      // hue circle colour of one count, integer form
      function pixel_colour_type hue_colour(logic [icc_pkg::COUNT_W-1:0] count);
         int unsigned      limit;
         int unsigned      six;
         int unsigned      sector;
         int unsigned      remainder;
         int unsigned      rise;
         int unsigned      fall;
         pixel_colour_type c;
         limit = (max_iter == 0) ? 1 : int'(max_iter);
         c = '0;
         if (count != 0) begin
            six       = 6 * count;
            sector    = six / limit;
            remainder = six % limit;
            rise      = (255 * remainder) / limit;
            fall      = (255 * (limit - remainder)) / limit;
            case (sector)
               icc_pkg::SEC_GREEN_UP: begin
                  c.red   = icc_pkg::CHAN_FULL;
                  c.green = rise[icc_pkg::CHAN_W-1:0];
                  c.blue  = '0;
               end
               icc_pkg::SEC_RED_DOWN: begin
                  c.red   = fall[icc_pkg::CHAN_W-1:0];
                  c.green = icc_pkg::CHAN_FULL;
                  c.blue  = '0;
               end
               icc_pkg::SEC_BLUE_UP: begin
                  c.red   = '0;
                  c.green = icc_pkg::CHAN_FULL;
                  c.blue  = rise[icc_pkg::CHAN_W-1:0];
               end
               icc_pkg::SEC_GREEN_DN: begin
                  c.red   = '0;
                  c.green = fall[icc_pkg::CHAN_W-1:0];
                  c.blue  = icc_pkg::CHAN_FULL;
               end
               icc_pkg::SEC_RED_UP: begin
                  c.red   = rise[icc_pkg::CHAN_W-1:0];
                  c.green = '0;
                  c.blue  = icc_pkg::CHAN_FULL;
               end
               default: begin
                  c.red   = icc_pkg::CHAN_FULL;
                  c.green = '0;
                  c.blue  = fall[icc_pkg::CHAN_W-1:0];
               end
            endcase
         end
         return c;
      endfunction

      function void note_count(logic [icc_pkg::COUNT_W-1:0] count);
         expected_colours.push_back(hue_colour(count));
      endfunction

      function int pending();
         return expected_colours.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_colour(logic [icc_pkg::CHAN_W-1:0] red, logic [icc_pkg::CHAN_W-1:0] green,
                        logic [icc_pkg::CHAN_W-1:0] blue);
         pixel_colour_type want;
         if (expected_colours.size() == 0) begin
            report_mismatch($sformatf("unexpected colour %0d %0d %0d", red, green, blue));
         end else begin
            want = expected_colours.pop_front();
            if (red !== want.red)
               report_mismatch($sformatf("red got %0d expected %0d", red, want.red));
            if (green !== want.green)
               report_mismatch($sformatf("green got %0d expected %0d", green, want.green));
            if (blue !== want.blue)
               report_mismatch($sformatf("blue got %0d expected %0d", blue, want.blue));
         end
      endtask
   endclass

   // every input known from time zero
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [icc_pkg::COUNT_W-1:0] req_iteration_count = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [icc_pkg::CHAN_W-1:0]  rsp_red;
   logic [icc_pkg::CHAN_W-1:0]  rsp_green;
   logic [icc_pkg::CHAN_W-1:0]  rsp_blue;
   logic                        csr_write_enable = 1'b0;
   logic [icc_pkg::COUNT_W-1:0] csr_write_data = '0;

   colour_scoreboard board;

   // idling controls shared between the sender, the receiver and the main flow
   bit sender_gaps   = 1'b1;
   bit receiver_gaps = 1'b1;
   bit hold_request  = 1'b0;
   int unsigned quiet_cycles = 0;

   iteration_count_colorizer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_iteration_count (req_iteration_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #1 clock = ~clock;

   // offer one count, optionally after a short gap, and note it once accepted
   task send_count(input logic [icc_pkg::COUNT_W-1:0] count);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_iteration_count <= count;
      do @(posedge clock); while (req_stall);
      board.note_count(count);
   endtask

   // stop offering and let every outstanding colour come back
   task drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // the block is idle here, so the new limit applies to every later count
   task write_max_iter(input logic [icc_pkg::COUNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.max_iter = value;
   endtask

   // mostly counts on the hue circle, some black, some past the limit,
   // some across the whole field so every bit toggles
   function logic [icc_pkg::COUNT_W-1:0] pick_count();
      int unsigned kind;
      int unsigned limit;
      kind  = $urandom_range(0, 9);
      limit = (board.max_iter == 0) ? 1 : int'(board.max_iter);
      case (kind)
         0:       return '0;
         1:       return icc_pkg::COUNT_W'($urandom_range(0, 255));
         2:       return icc_pkg::COUNT_W'($urandom_range(limit, 255));
         default: return icc_pkg::COUNT_W'($urandom_range(1, limit));
      endcase
   endfunction

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_gaps && !reset && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor: every accepted colour against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_colour(rsp_red, rsp_green, rsp_blue);
   end

   // watchdog: count cycles in which neither channel moves a transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [icc_pkg::COUNT_W-1:0] directed_counts [23];
      logic [icc_pkg::COUNT_W-1:0] phase_max_iter [PHASE_COUNT];
      board = new();
      // sector boundaries for a limit of 100, black, and counts past the limit
      directed_counts = '{8'd0, 8'd1, 8'd255, 8'd16, 8'd17, 8'd33, 8'd34, 8'd50,
                          8'd51, 8'd66, 8'd67, 8'd83, 8'd84, 8'd99, 8'd100, 8'd101,
                          8'd200, 8'd128, 8'd127, 8'd170, 8'd85, 8'd2, 8'd254};
      // extremes, zero limit (handled as one), tiny limits and a few random ones
      phase_max_iter = '{8'd1, 8'd255, 8'd0, 8'd6, 8'd7, 8'd100, 8'd3,
                         8'd0, 8'd0, 8'd0, 8'd0, 8'd254};
      for (int i = 7; i < 11; i++)
         phase_max_iter[i] = icc_pkg::COUNT_W'($urandom_range(1, 255));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the default limit
      write_max_iter(icc_pkg::MAX_ITER_RESET);
      foreach (directed_counts[i])
         send_count(directed_counts[i]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_results();
         write_max_iter(phase_max_iter[p]);
         // final phase runs flat out on both sides
         if (p == PHASE_COUNT - 1) begin
            sender_gaps   = 1'b0;
            receiver_gaps = 1'b0;
         end
         // long receiver hold-off while counts keep coming, so the pipe fills
         if (p == FLOOD_PHASE) begin
            sender_gaps  = 1'b0;
            hold_request = 1'b1;
            for (int i = 0; i < FLOOD_ITEMS; i++)
               send_count(pick_count());
            sender_gaps = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_count(pick_count());
      end

      drain_results();
      // extra cycles to catch any stray colour after the last one
      repeat (2 * LATENCY) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
